/* rtl/core/aps_pkg.sv */
// Shared constants, types and helpers for the anisotropic Piola stress unit.
package aps_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int COEFS        = 36;
    localparam int TBL_DEPTH    = MAX_ELEMENTS * COEFS;
    localparam int ADDR_W       = $clog2(TBL_DEPTH);
    localparam int COEF_W       = 48;
    localparam int F_W          = 32;
    localparam int E_W          = 37;
    localparam int A_W          = 38;
    localparam int B_W          = 33;
    localparam int PROD_W       = A_W + B_W;
    localparam int ACC_W        = 100;
    localparam int OUT_W        = 64;

    localparam logic [1:0] SH_0  = 2'd0;
    localparam logic [1:0] SH_24 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;

    localparam logic MODE_COEF = 1'b0;
    localparam logic MODE_ROW  = 1'b1;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic                    vld;
        logic                    first;
        logic                    last;
        logic [1:0]              sh;
        logic signed [A_W-1:0]   a;
        logic signed [B_W-1:0]   b;
    } mac_op_t;

    typedef struct packed {
        logic vld;
        acc_t sum;
    } mac_res_t;

    typedef struct packed {
        logic                    ovf;
        logic signed [OUT_W-1:0] val;
    } sat_t;

    // Voigt index of the symmetric stress entry (k, j)
    function automatic logic [2:0] voigt(input logic [1:0] k, input logic [1:0] j);
        logic [2:0] v;
        begin
            if (k == j)
                v = {1'b0, k};
            else
                v = 3'd6 - {1'b0, k} - {1'b0, j};
            return v;
        end
    endfunction

    function automatic logic [1:0] green_row(input logic [2:0] d);
        logic [1:0] r;
        begin
            case (d)
                3'd0, 3'd4, 3'd5: r = 2'd0;
                3'd1, 3'd3:       r = 2'd1;
                3'd2:             r = 2'd2;
                default:          r = 2'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [1:0] green_col(input logic [2:0] d);
        logic [1:0] c;
        begin
            case (d)
                3'd0:             c = 2'd0;
                3'd1, 3'd5:       c = 2'd1;
                3'd2, 3'd3, 3'd4: c = 2'd2;
                default:          c = 2'd0;
            endcase
            return c;
        end
    endfunction

endpackage

/* rtl/core/aps_ram.sv */
// Generic simple dual-port RAM with registered read.
module aps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

/* rtl/core/aps_mac.sv */
// Shared multiply-accumulate unit: registered product, then wide accumulate.
module aps_mac (
    input  logic             clk,
    input  logic             rst_n,
    input  aps_pkg::mac_op_t op,
    output aps_pkg::mac_res_t res,
    output logic             busy
);

    logic                                  pr_vld_reg;
    logic                                  pr_first_reg;
    logic                                  pr_last_reg;
    logic [1:0]                            pr_sh_reg;
    logic signed [aps_pkg::PROD_W-1:0]     pr_reg;
    aps_pkg::acc_t                         acc_reg;
    logic                                  fin_vld_reg;
    aps_pkg::acc_t                         ext;
    aps_pkg::acc_t                         addend;

    always_comb
    begin
        ext = aps_pkg::acc_t'(pr_reg);
        case (pr_sh_reg)
            aps_pkg::SH_24: addend = ext <<< 24;
            aps_pkg::SH_32: addend = ext <<< 32;
            default:        addend = ext;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
        end
        else
        begin
            pr_vld_reg  <= op.vld;
            fin_vld_reg <= pr_vld_reg & pr_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.vld)
        begin
            pr_reg       <= op.a * op.b;
            pr_first_reg <= op.first;
            pr_last_reg  <= op.last;
            pr_sh_reg    <= op.sh;
        end
        if (pr_vld_reg)
            acc_reg <= (pr_first_reg ? '0 : acc_reg) + addend;
    end

    assign res.vld = fin_vld_reg;
    assign res.sum = acc_reg;
    assign busy    = pr_vld_reg | fin_vld_reg;

endmodule

/* rtl/core/anisotropic_piola_stress_unit.sv */
// Top level: item decode, stiffness table, sequencer and result registers.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | in_valid / in_ready     | mode, element, slot, coefficient, grad_x/y/z
//  output   | out_valid / out_ready   | p_00 .. p_22, saturated
//  config   | cfg_we (no wait)        | cfg_data (strain_kind)
//
// Load items and gradient rows 0 and 1 are taken while the sequencer stays idle.
// A row 2 item runs the shared multiplier: 18 Green products (strain_kind set
// only), 72 half-width stiffness and 54 half-width stress products, plus drains.
// The stiffness table is one RAM; each coefficient is read the cycle before use.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output registers while the next item is taken.
module anisotropic_piola_stress_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [5:0]         element,
    input  logic [5:0]         slot,
    input  logic signed [47:0] coefficient,
    input  logic signed [31:0] grad_x,
    input  logic signed [31:0] grad_y,
    input  logic signed [31:0] grad_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] p_00,
    output logic signed [63:0] p_01,
    output logic signed [63:0] p_02,
    output logic signed [63:0] p_10,
    output logic signed [63:0] p_11,
    output logic signed [63:0] p_12,
    output logic signed [63:0] p_20,
    output logic signed [63:0] p_21,
    output logic signed [63:0] p_22,
    output logic               saturated
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CAUCHY = 3'd1;
    localparam logic [2:0] S_PRIME  = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    localparam logic [1:0] PH_GREEN = 2'd0;
    localparam logic [1:0] PH_KE    = 2'd1;
    localparam logic [1:0] PH_P     = 2'd2;

    localparam int AW = aps_pkg::ADDR_W;
    localparam aps_pkg::acc_t GREEN_ONE = aps_pkg::acc_t'(1) <<< 56;
    localparam logic signed [aps_pkg::E_W-1:0] Q28_ONE = aps_pkg::E_W'(1) <<< 28;

    logic [2:0]   state_reg, state_next;
    logic [1:0]   phase_reg;
    logic         kind_reg;
    logic [2:0]   i_reg;
    logic [2:0]   j_reg;
    logic [1:0]   k_reg;
    logic         h_reg;
    logic [3:0]   fin_idx_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] ca_reg;
    logic         sat_acc_reg;
    logic         out_vld_reg;
    logic         out_sat_reg;

    logic signed [aps_pkg::F_W-1:0]   grad_reg [2][3];
    logic signed [aps_pkg::F_W-1:0]   f2_reg [3];
    logic signed [aps_pkg::F_W-1:0]   f [3][3];
    logic signed [aps_pkg::E_W-1:0]   e_reg [6];
    logic signed [aps_pkg::OUT_W-1:0] s_reg [6];
    logic signed [aps_pkg::OUT_W-1:0] pw_reg [9];
    logic signed [aps_pkg::OUT_W-1:0] po_reg [9];

    logic               in_acc;
    logic               elem_ok;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [aps_pkg::COEF_W-1:0] ram_rdata;
    logic               phase_end;
    logic               out_free;

    aps_pkg::mac_op_t   mac_op;
    aps_pkg::mac_res_t  mac_res;
    logic               mac_busy;

    aps_pkg::acc_t      green_diag;
    aps_pkg::acc_t      green_shear;
    aps_pkg::sat_t      s_sat;
    aps_pkg::sat_t      p_sat;
    logic [1:0]         gr;
    logic [1:0]         gc;
    logic signed [aps_pkg::OUT_W-1:0] sv;

    function automatic aps_pkg::sat_t sat64(input aps_pkg::acc_t v);
        aps_pkg::sat_t r;
        logic [aps_pkg::ACC_W-aps_pkg::OUT_W:0] hi;
        begin
            hi    = v[aps_pkg::ACC_W-1:aps_pkg::OUT_W-1];
            r.ovf = !((&hi) | (~|hi));
            if (!r.ovf)
                r.val = v[aps_pkg::OUT_W-1:0];
            else if (v[aps_pkg::ACC_W-1])
                r.val = {1'b1, {(aps_pkg::OUT_W-1){1'b0}}};
            else
                r.val = {1'b0, {(aps_pkg::OUT_W-1){1'b1}}};
            return r;
        end
    endfunction

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid & in_ready;
    assign elem_ok   = (32'(element) < 32'(aps_pkg::MAX_ELEMENTS));
    assign out_free  = !out_vld_reg || out_ready;

    // gradient with row 2 taken from the triggering item
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            f[0][c] = grad_reg[0][c];
            f[1][c] = grad_reg[1][c];
            f[2][c] = f2_reg[c];
        end
    end

    // stiffness table
    assign ram_we    = in_acc && elem_ok && (mode == aps_pkg::MODE_COEF)
                       && (32'(slot) < 32'(aps_pkg::COEFS));
    assign ram_waddr = AW'(element) * AW'(aps_pkg::COEFS) + AW'(slot);
    assign ram_re    = (state_reg == S_PRIME)
                       || (state_reg == S_RUN && phase_reg == PH_KE && h_reg
                           && !(i_reg == 3'd5 && j_reg == 3'd5));
    assign ram_raddr = (state_reg == S_PRIME) ? base_reg : ca_reg;

    aps_ram #(
        .WIDTH (aps_pkg::COEF_W),
        .DEPTH (aps_pkg::TBL_DEPTH)
    ) u_tbl (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (coefficient),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // operand selection
    always_comb
    begin
        gr       = aps_pkg::green_row(i_reg);
        gc       = aps_pkg::green_col(i_reg);
        sv       = s_reg[aps_pkg::voigt(k_reg, j_reg[1:0])];
        mac_op   = '0;
        phase_end = 1'b0;
        if (state_reg == S_RUN)
        begin
            mac_op.vld = 1'b1;
            unique case (phase_reg)
                PH_GREEN:
                begin
                    mac_op.a     = aps_pkg::A_W'(f[k_reg][gr]);
                    mac_op.b     = aps_pkg::B_W'(f[k_reg][gc]);
                    mac_op.sh    = aps_pkg::SH_0;
                    mac_op.first = (k_reg == 2'd0);
                    mac_op.last  = (k_reg == 2'd2);
                    phase_end    = (i_reg == 3'd5) && (k_reg == 2'd2);
                end
                PH_KE:
                begin
                    mac_op.a = aps_pkg::A_W'(e_reg[j_reg]);
                    if (h_reg)
                    begin
                        mac_op.b  = aps_pkg::B_W'($signed(ram_rdata[47:24]));
                        mac_op.sh = aps_pkg::SH_24;
                    end
                    else
                    begin
                        mac_op.b  = $signed({9'd0, ram_rdata[23:0]});
                        mac_op.sh = aps_pkg::SH_0;
                    end
                    mac_op.first = (j_reg == 3'd0) && !h_reg;
                    mac_op.last  = (j_reg == 3'd5) && h_reg;
                    phase_end    = (i_reg == 3'd5) && (j_reg == 3'd5) && h_reg;
                end
                PH_P:
                begin
                    if (h_reg)
                    begin
                        mac_op.a  = aps_pkg::A_W'($signed(sv[63:32]));
                        mac_op.sh = aps_pkg::SH_32;
                    end
                    else
                    begin
                        mac_op.a  = $signed({6'd0, sv[31:0]});
                        mac_op.sh = aps_pkg::SH_0;
                    end
                    mac_op.b     = aps_pkg::B_W'(f[i_reg[1:0]][k_reg]);
                    mac_op.first = (k_reg == 2'd0) && !h_reg;
                    mac_op.last  = (k_reg == 2'd2) && h_reg;
                    phase_end    = (i_reg == 3'd2) && (j_reg == 3'd2)
                                   && (k_reg == 2'd2) && h_reg;
                end
                default:
                begin
                    mac_op.vld = 1'b0;
                end
            endcase
        end
    end

    aps_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .res   (mac_res),
        .busy  (mac_busy)
    );

    // finishing of a completed sum
    assign green_diag  = (mac_res.sum - GREEN_ONE) >>> 29;
    assign green_shear = mac_res.sum >>> 28;
    assign s_sat       = sat64(mac_res.sum >>> 20);
    assign p_sat       = sat64(mac_res.sum >>> 28);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_acc && elem_ok && mode == aps_pkg::MODE_ROW && slot == 6'd2)
                    state_next = kind_reg ? S_RUN : S_CAUCHY;
            S_CAUCHY:
                state_next = S_PRIME;
            S_PRIME:
                state_next = S_RUN;
            S_RUN:
                if (phase_end)
                    state_next = S_DRAIN;
            S_DRAIN:
                if (!mac_busy)
                begin
                    unique case (phase_reg)
                        PH_GREEN: state_next = S_PRIME;
                        PH_KE:    state_next = S_RUN;
                        default:  state_next = S_DONE;
                    endcase
                end
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_GREEN;
            kind_reg    <= 1'b1;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            h_reg       <= 1'b0;
            fin_idx_reg <= '0;
            sat_acc_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            out_sat_reg <= 1'b0;
            for (int r = 0; r < 2; r++)
                for (int c = 0; c < 3; c++)
                    grad_reg[r][c] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                kind_reg <= cfg_data;

            if (in_acc && elem_ok && mode == aps_pkg::MODE_ROW && slot < 6'd2)
            begin
                grad_reg[slot[0]][0] <= grad_x;
                grad_reg[slot[0]][1] <= grad_y;
                grad_reg[slot[0]][2] <= grad_z;
            end

            if (state_reg == S_IDLE && state_next != S_IDLE)
            begin
                phase_reg   <= kind_reg ? PH_GREEN : PH_KE;
                i_reg       <= '0;
                k_reg       <= '0;
                fin_idx_reg <= '0;
                sat_acc_reg <= 1'b0;
            end

            if (state_reg == S_PRIME)
            begin
                phase_reg <= PH_KE;
                i_reg     <= '0;
                j_reg     <= '0;
                h_reg     <= 1'b0;
            end

            if (state_reg == S_RUN)
            begin
                unique case (phase_reg)
                    PH_GREEN:
                        if (k_reg == 2'd2)
                        begin
                            k_reg <= '0;
                            i_reg <= i_reg + 3'd1;
                        end
                        else
                            k_reg <= k_reg + 2'd1;
                    PH_KE:
                        if (!h_reg)
                            h_reg <= 1'b1;
                        else
                        begin
                            h_reg <= 1'b0;
                            if (j_reg == 3'd5)
                            begin
                                j_reg <= '0;
                                i_reg <= i_reg + 3'd1;
                            end
                            else
                                j_reg <= j_reg + 3'd1;
                        end
                    default:
                        if (!h_reg)
                            h_reg <= 1'b1;
                        else
                        begin
                            h_reg <= 1'b0;
                            if (k_reg == 2'd2)
                            begin
                                k_reg <= '0;
                                if (j_reg == 3'd2)
                                begin
                                    j_reg <= '0;
                                    i_reg <= i_reg + 3'd1;
                                end
                                else
                                    j_reg <= j_reg + 3'd1;
                            end
                            else
                                k_reg <= k_reg + 2'd1;
                        end
                endcase
            end

            if (state_reg == S_DRAIN && !mac_busy)
            begin
                fin_idx_reg <= '0;
                if (phase_reg == PH_KE)
                begin
                    phase_reg <= PH_P;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    k_reg     <= '0;
                    h_reg     <= 1'b0;
                end
            end
            else if (mac_res.vld)
            begin
                fin_idx_reg <= fin_idx_reg + 4'd1;
                if (phase_reg != PH_GREEN)
                    sat_acc_reg <= sat_acc_reg | (phase_reg == PH_KE ? s_sat.ovf : p_sat.ovf);
            end

            if (state_reg == S_DONE && out_free)
            begin
                out_vld_reg <= 1'b1;
                out_sat_reg <= sat_acc_reg;
            end
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc && mode == aps_pkg::MODE_ROW && slot == 6'd2)
        begin
            f2_reg[0] <= grad_x;
            f2_reg[1] <= grad_y;
            f2_reg[2] <= grad_z;
            base_reg  <= AW'(element) * AW'(aps_pkg::COEFS);
        end
        if (state_reg == S_PRIME)
            ca_reg <= base_reg + AW'(1);
        else if (ram_re)
            ca_reg <= ca_reg + AW'(1);

        if (state_reg == S_CAUCHY)
        begin
            // small strain: diagonal less one, shear as doubled mean
            for (int d = 0; d < 3; d++)
                e_reg[d] <= aps_pkg::E_W'(f[d][d]) - Q28_ONE;
            e_reg[3] <= aps_pkg::E_W'(f[1][2]) + aps_pkg::E_W'(f[2][1]);
            e_reg[4] <= aps_pkg::E_W'(f[0][2]) + aps_pkg::E_W'(f[2][0]);
            e_reg[5] <= aps_pkg::E_W'(f[0][1]) + aps_pkg::E_W'(f[1][0]);
        end

        if (mac_res.vld)
        begin
            unique case (phase_reg)
                PH_GREEN:
                    e_reg[fin_idx_reg[2:0]] <= (fin_idx_reg < 4'd3)
                        ? green_diag[aps_pkg::E_W-1:0]
                        : green_shear[aps_pkg::E_W-1:0];
                PH_KE:
                    s_reg[fin_idx_reg[2:0]] <= s_sat.val;
                default:
                    pw_reg[fin_idx_reg] <= p_sat.val;
            endcase
        end

        if (state_reg == S_DONE && out_free)
            for (int n = 0; n < 9; n++)
                po_reg[n] <= pw_reg[n];
    end

    assign out_valid = out_vld_reg;
    assign saturated = out_sat_reg;
    assign p_00 = po_reg[0];
    assign p_01 = po_reg[1];
    assign p_02 = po_reg[2];
    assign p_10 = po_reg[3];
    assign p_11 = po_reg[4];
    assign p_12 = po_reg[5];
    assign p_20 = po_reg[6];
    assign p_21 = po_reg[7];
    assign p_22 = po_reg[8];

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !mac_busy)
        else $error("multiplier busy while idle");

    a_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (phase_reg == PH_KE || state_reg == S_PRIME))
        else $error("table read outside stiffness phase");

    a_fin_range: assert property (@(posedge clk) disable iff (!rst_n)
        (mac_res.vld && phase_reg == PH_P) |-> (fin_idx_reg < 4'd9))
        else $error("stress index overrun");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> out_valid)
        else $error("finished item not presented");

endmodule
